>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ready-queue scheduler.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property check on a clock, held off during reset.
`define PRQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression that must never be true, checked on a clock, held off during reset.
`define PRQ_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PRQ_ASSERT(label, clk, rst_n, prop, msg)
`define PRQ_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> hdl/prq_pkg.sv
// Package of the ready-queue scheduler: sizes, codes, item types, state enum
// and pointer helpers. No dependencies.
package prq_pkg;

	localparam int LEVELS      = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS  = LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	localparam int ID_W   = 8;
	localparam int REQ_W  = 2;
	localparam int PRIO_W = 4;
	localparam int STAT_W = 3;

	localparam logic [ID_W-1:0] IDLE_ID = 8'd1;

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_NEXT   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_PRIO  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_IDLE      = 3'd4;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] prio_level;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   chosen_id;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PICK_WAIT,
		S_DONE
	} state_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
	endfunction

	// flat slot address: level * depth + pointer
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
			input logic [PTR_W-1:0] ptr);
		return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
	endfunction

endpackage

>>> hdl/prq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/priority_ready_queue_scheduler.sv
// Top level of the multilevel strict-priority ready queue.
// Uses prq_pkg, prq_ram and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  req     | in        | req_valid / req_ready | req_type, task_id, prio_level
//  rsp     | out       | rsp_valid / rsp_ready | chosen_id, status
//
// Add, any rejected request and pick next on empty queues go from decode straight to
// done; pick next that dequeues passes a RAM read wait state. Remove walks the level:
// each step is a read, then a compare or write on the single slot RAM port.
// Reset empties all levels through the fill counts.
// One request in flight; req_ready is high only in idle.
// A result waits in the output register under stall; done holds until it is free.
`include "assert_macros.svh"

module priority_ready_queue_scheduler
	import prq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// sequencer state and latched request
	state_t             state_q, state_d;
	logic [REQ_W-1:0]   req_type_q;
	logic [ID_W-1:0]    id_q;
	logic [LVL_W-1:0]   lvl_q, lvl_d;
	logic               bad_q;

	// walk pointer and index inside the level during remove
	logic [PTR_W-1:0]   pos_q, pos_d;
	logic [CNT_W-1:0]   idx_q, idx_d;

	// pending result
	logic [ID_W-1:0]    res_id_q, res_id_d;
	logic [STAT_W-1:0]  res_st_q, res_st_d;
	logic               res_set;

	// output register
	rsp_t               out_q;
	logic               out_valid_q;
	logic               out_load;

	// per-level queue pointers
	logic [PTR_W-1:0]   head_q [LEVELS];
	logic [PTR_W-1:0]   tail_q [LEVELS];
	logic [CNT_W-1:0]   fill_q [LEVELS];

	logic               add_commit, rem_commit, pick_commit;

	// slot RAM port
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [ID_W-1:0]    ram_wdata, ram_rdata;

	logic               accept, in_bad;
	logic [CNT_W-1:0]   cur_fill, fill_dec;
	logic [PTR_W-1:0]   cur_head, cur_tail, pos_nxt;
	logic               last_idx;
	logic               pick_found;
	logic [LVL_W-1:0]   pick_lvl;
	logic               walk_st, we_ok;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// a level at or above the level count is rejected for add and remove
	assign in_bad = ({1'b0, req.prio_level} >= (PRIO_W + 1)'(LEVELS));

	assign cur_fill = fill_q[lvl_q];
	assign fill_dec = cur_fill - CNT_W'(1);
	assign cur_head = head_q[lvl_q];
	assign cur_tail = tail_q[lvl_q];
	assign pos_nxt  = ptr_inc(pos_q);
	assign last_idx = ((idx_q + CNT_W'(1)) == cur_fill);

	// remove walk states, and states allowed to write the slot RAM
	assign walk_st = (state_q == S_SCAN_RD) || (state_q == S_SCAN_CMP) ||
		(state_q == S_SHIFT_RD) || (state_q == S_SHIFT_WR);
	assign we_ok   = (state_q == S_DECODE) || (state_q == S_SHIFT_WR);

	// lowest-numbered non-empty level
	always_comb begin
		pick_found = 1'b0;
		pick_lvl   = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (fill_q[l] != '0) begin
				pick_found = 1'b1;
				pick_lvl   = LVL_W'(l);
			end
		end
	end

	prq_ram #(
		.WIDTH (ID_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM control and commit strobes
	always_comb begin
		state_d     = state_q;
		lvl_d       = lvl_q;
		pos_d       = pos_q;
		idx_d       = idx_q;
		res_set     = 1'b0;
		res_id_d    = '0;
		res_st_d    = ST_OK;
		ram_we      = 1'b0;
		ram_waddr   = slot_addr(lvl_q, cur_tail);
		ram_wdata   = id_q;
		ram_raddr   = slot_addr(lvl_q, pos_q);
		add_commit  = 1'b0;
		rem_commit  = 1'b0;
		pick_commit = 1'b0;
		out_load    = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					lvl_d   = in_bad ? '0 : req.prio_level[LVL_W-1:0];
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (req_type_q)
					REQ_ADD: begin
						res_set = 1'b1;
						state_d = S_DONE;
						if (bad_q) begin
							res_st_d = ST_BAD_PRIO;
						end else if (cur_fill >= CNT_W'(QUEUE_DEPTH)) begin
							res_st_d = ST_FULL;
						end else begin
							ram_we     = 1'b1;
							add_commit = 1'b1;
						end
					end
					REQ_REMOVE: begin
						if (bad_q) begin
							res_set  = 1'b1;
							res_st_d = ST_BAD_PRIO;
							state_d  = S_DONE;
						end else if (cur_fill == '0) begin
							res_set  = 1'b1;
							res_st_d = ST_NOT_FOUND;
							state_d  = S_DONE;
						end else begin
							pos_d   = cur_head;
							idx_d   = '0;
							state_d = S_SCAN_RD;
						end
					end
					REQ_NEXT: begin
						if (pick_found) begin
							lvl_d     = pick_lvl;
							ram_raddr = slot_addr(pick_lvl, head_q[pick_lvl]);
							state_d   = S_PICK_WAIT;
						end else begin
							res_set  = 1'b1;
							res_id_d = IDLE_ID;
							res_st_d = ST_IDLE;
							state_d  = S_DONE;
						end
					end
					default: begin
						res_set = 1'b1;
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (ram_rdata == id_q) begin
					state_d = S_SHIFT_RD;
				end else if (last_idx) begin
					res_set  = 1'b1;
					res_st_d = ST_NOT_FOUND;
					state_d  = S_DONE;
				end else begin
					pos_d   = pos_nxt;
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				if (last_idx) begin
					rem_commit = 1'b1;
					res_set    = 1'b1;
					state_d    = S_DONE;
				end else begin
					ram_raddr = slot_addr(lvl_q, pos_nxt);
					state_d   = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				// pull the later entry one place toward the head
				ram_we    = 1'b1;
				ram_waddr = slot_addr(lvl_q, pos_q);
				ram_wdata = ram_rdata;
				pos_d     = pos_nxt;
				idx_d     = idx_q + CNT_W'(1);
				state_d   = S_SHIFT_RD;
			end
			S_PICK_WAIT: begin
				pick_commit = 1'b1;
				res_set     = 1'b1;
				res_id_d    = ram_rdata;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// request latch, walk registers, pending result and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			id_q       <= req.task_id;
			bad_q      <= in_bad;
		end
		lvl_q <= lvl_d;
		pos_q <= pos_d;
		idx_q <= idx_d;
		if (res_set) begin
			res_id_q <= res_id_d;
			res_st_q <= res_st_d;
		end
		if (out_load) begin
			out_q.chosen_id <= res_id_q;
			out_q.status    <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// queue pointers; reset leaves every level empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				fill_q[l] <= '0;
			end
		end else begin
			if (add_commit) begin
				tail_q[lvl_q] <= ptr_inc(cur_tail);
				fill_q[lvl_q] <= cur_fill + CNT_W'(1);
			end
			if (rem_commit) begin
				tail_q[lvl_q] <= ptr_dec(cur_tail);
				fill_q[lvl_q] <= fill_dec;
			end
			if (pick_commit) begin
				head_q[lvl_q] <= ptr_inc(cur_head);
				fill_q[lvl_q] <= fill_dec;
			end
		end
	end

	// slot RAM is written only by an add or a shift step
	`PRQ_NEVER(a_ram_we_state, clk, arst_n, ram_we && !we_ok, "slot write outside add or shift")
	// the walk index stays inside the level's held entries
	`PRQ_ASSERT(a_idx_range, clk, arst_n, walk_st |-> (idx_q < cur_fill), "walk past fill count")
	// a dequeue lowers that level's fill count by one; the level holds in done
	`PRQ_ASSERT(a_pick_fill, clk, arst_n, pick_commit |=> (cur_fill == $past(fill_dec)), "fill not dropped")

endmodule

>>> verif/testbench.sv
// Testbench for priority_ready_queue_scheduler: random and directed requests against a
// cycle-free model of the per-level task FIFOs, with a scoreboard class for the results.
// Depends on prq_pkg (sizes, request and status codes, req_t and rsp_t) and the RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import prq_pkg::*;

	// Request code 3 has no name in the package; the block must answer it with ok and id 0.
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1100;
	// A remove on a full level is the longest request, so this covers any
	// request still in flight once the last result is back.
	localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
	// The limit sits well above the slowest honest run of roughly 1130 items
	// with long removes, stalls and gaps.
	localparam int CYCLE_LIMIT = 400000;

	// Keeps a copy of every level's FIFO, predicts the result of each accepted
	// request and checks the block's results against them in order.
	class sched_scoreboard;
		bit [ID_W-1:0] lvl_slots [LEVELS][QUEUE_DEPTH];
		int lvl_head [LEVELS];
		int lvl_tail [LEVELS];
		int lvl_fill [LEVELS];
		rsp_t due_rsp [$];
		int mismatches;
		int checked;
		int req_tally [4];
		int stat_tally [8];

		function new();
			mismatches = 0;
			checked = 0;
		endfunction

		function int wrap_up(int p);
			return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
		endfunction

		function int wrap_down(int p);
			return (p == 0) ? QUEUE_DEPTH - 1 : p - 1;
		endfunction

		function int pending();
			return due_rsp.size();
		endfunction

		// id held at place idx counted from the head of a level
		function bit [ID_W-1:0] held_id(int lvl, int idx);
			return lvl_slots[lvl][(lvl_head[lvl] + idx) % QUEUE_DEPTH];
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int lvl;
			int pos;
			int n;
			bit hit;
			e = '0;
			e.status = ST_OK;
			lvl = int'(r.prio_level);
			hit = 1'b0;
			case (r.req_type)
				REQ_ADD, REQ_REMOVE: begin
					if (lvl >= LEVELS) begin
						e.status = ST_BAD_PRIO;
					end else if (r.req_type == REQ_ADD) begin
						if (lvl_fill[lvl] >= QUEUE_DEPTH) begin
							e.status = ST_FULL;
						end else begin
							lvl_slots[lvl][lvl_tail[lvl]] = r.task_id;
							lvl_tail[lvl] = wrap_up(lvl_tail[lvl]);
							lvl_fill[lvl]++;
						end
					end else begin
						pos = lvl_head[lvl];
						n = lvl_fill[lvl];
						for (int i = 0; i < n && !hit; i++) begin
							if (lvl_slots[lvl][pos] == r.task_id) begin
								hit = 1'b1;
								// close the gap toward the head
								for (int k = i; k + 1 < n; k++) begin
									lvl_slots[lvl][pos] = lvl_slots[lvl][wrap_up(pos)];
									pos = wrap_up(pos);
								end
								lvl_fill[lvl] = n - 1;
								lvl_tail[lvl] = wrap_down(lvl_tail[lvl]);
							end else begin
								pos = wrap_up(pos);
							end
						end
						if (!hit)
							e.status = ST_NOT_FOUND;
					end
				end
				REQ_NEXT: begin
					for (int q = 0; q < LEVELS && !hit; q++) begin
						if (lvl_fill[q] > 0) begin
							hit = 1'b1;
							e.chosen_id = lvl_slots[q][lvl_head[q]];
							lvl_head[q] = wrap_up(lvl_head[q]);
							lvl_fill[q]--;
						end
					end
					if (!hit) begin
						e.chosen_id = IDLE_ID;
						e.status = ST_IDLE;
					end
				end
				default: ;
			endcase
			req_tally[r.req_type]++;
			stat_tally[e.status]++;
			due_rsp.push_back(e);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] result %0d: %s", $time, checked, msg);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			checked++;
			if (due_rsp.size() == 0) begin
				flag($sformatf("nothing due, got id %0d status %0d", got.chosen_id, got.status));
				return;
			end
			e = due_rsp.pop_front();
			if (got.chosen_id !== e.chosen_id)
				flag($sformatf("chosen_id expected %0d got %0d", e.chosen_id, got.chosen_id));
			if (got.status !== e.status)
				flag($sformatf("status expected %0d got %0d", e.status, got.status));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// no idling on either side while set
	logic quiet = 1'b0;
	int cycles = 0;
	int sent = 0;
	sched_scoreboard sb;

	priority_ready_queue_scheduler uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycles, sb.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Downstream stalls about 31% of cycles, except during the quiet stretch.
	always @(posedge clk)
		rsp_ready <= quiet || ($urandom_range(99) >= 31);

	// Every result taken at this edge is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	function automatic req_t mk_req(logic [REQ_W-1:0] t, logic [ID_W-1:0] id,
			logic [PRIO_W-1:0] p);
		req_t r;
		r.req_type = t;
		r.task_id = id;
		r.prio_level = p;
		return r;
	endfunction

	// Offer one item, with random idle cycles ahead of it, and hold it until taken.
	// valid stays high across back-to-back items, so it is only lowered in a gap.
	task automatic send_req(input req_t r);
		while (!quiet && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(r);
		sent++;
	endtask

	// Mostly well-formed traffic. In grow phases adds dominate so levels fill up and
	// hit the full case; in drain phases picks dominate so the idle answer shows up.
	// Removes usually name an id that sits somewhere in the level, so the search and
	// shift paths run at every depth; a few items are bad priorities or code 3.
	function automatic req_t random_req(bit grow);
		int roll;
		int lvl;
		logic [ID_W-1:0] id;
		roll = $urandom_range(99);
		lvl = ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(LEVELS - 1);
		// small ids give plenty of duplicates
		id = ($urandom_range(1) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom_range(255));
		if (roll < 5) begin
			if ($urandom_range(1) == 0)
				return mk_req(REQ_SPARE, id, PRIO_W'($urandom_range(15)));
			return mk_req(REQ_W'($urandom_range(1)), id,
				PRIO_W'($urandom_range(15, LEVELS)));
		end
		if (roll < (grow ? 55 : 20))
			return mk_req(REQ_ADD, id, PRIO_W'(lvl));
		if (roll < (grow ? 75 : 42)) begin
			if (sb.lvl_fill[lvl] > 0 && $urandom_range(3) != 0)
				id = sb.held_id(lvl, $urandom_range(sb.lvl_fill[lvl] - 1));
			return mk_req(REQ_REMOVE, id, PRIO_W'(lvl));
		end
		// pick next: fields are don't-care, drive them anyway
		return mk_req(REQ_NEXT, id, PRIO_W'($urandom_range(15)));
	endfunction

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		// pick next with every level empty returns the idle id; its fields are ignored
		send_req(mk_req(REQ_NEXT, 8'hFF, 4'hF));
		// unused request code
		send_req(mk_req(REQ_SPARE, 8'hFF, 4'hF));
		// priority out of range for add and for remove
		send_req(mk_req(REQ_ADD, 8'h10, PRIO_W'(LEVELS)));
		send_req(mk_req(REQ_REMOVE, 8'h10, 4'hF));
		// remove from an empty level: id absent
		send_req(mk_req(REQ_REMOVE, 8'h05, 4'd0));
		// fill the highest-numbered level to the brim, with id 0, id 255 and a duplicate
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_req(mk_req(REQ_ADD, (i == 0) ? 8'h00 : (i < 3) ? 8'hFF : ID_W'(i * 17),
				PRIO_W'(LEVELS - 1)));
		// one more is refused as full
		send_req(mk_req(REQ_ADD, 8'h42, PRIO_W'(LEVELS - 1)));
		// removes the first of the two 255s and shifts the rest up
		send_req(mk_req(REQ_REMOVE, 8'hFF, PRIO_W'(LEVELS - 1)));
		// level 3 wins the next pick, then the highest-numbered level's head goes
		send_req(mk_req(REQ_ADD, 8'hAA, 4'd3));
		send_req(mk_req(REQ_NEXT, 8'h00, 4'd0));
		send_req(mk_req(REQ_NEXT, 8'h00, 4'd0));
		// the id 0 just picked is gone now
		send_req(mk_req(REQ_REMOVE, 8'h00, PRIO_W'(LEVELS - 1)));

		// Random part.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet <= (n >= 400 && n < 650);
			if (n == 300) begin
				// let the block drain completely before going on
				req_valid <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_req(random_req(((n / 100) % 2) == 0));
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d add, %0d remove, %0d pick, %0d spare), checked %0d results",
			sent, sb.req_tally[REQ_ADD], sb.req_tally[REQ_REMOVE], sb.req_tally[REQ_NEXT],
			sb.req_tally[REQ_SPARE], sb.checked);
		$display("Outcomes: ok %0d, bad priority %0d, full %0d, not found %0d, idle %0d",
			sb.stat_tally[ST_OK], sb.stat_tally[ST_BAD_PRIO], sb.stat_tally[ST_FULL],
			sb.stat_tally[ST_NOT_FOUND], sb.stat_tally[ST_IDLE]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
